[design/quadratic_root_solver_unit_assert.svh]
// Assertion macros for the quadratic root solver.
// Expects clk and rst in the scope of each use; no other dependencies.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define QRS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qrs assertion failed");
`define QRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qrs assertion failed");
`else
`define QRS_ASSERT(label, prop)
`define QRS_ASSERT_IMPL(label, ante, cons)
`endif

`endif

[design/qrs_pkg.sv]
// Shared types and constants for the quadratic root solver.
// No dependencies.
`default_nettype none

package qrs_pkg;

  localparam int COEF_WIDTH = 32;

  localparam logic [1:0] ROOTS_NONE = 2'd0;
  localparam logic [1:0] ROOTS_ONE  = 2'd1;
  localparam logic [1:0] ROOTS_TWO  = 2'd2;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_A_ZERO = 1'b1;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } qrs_req_t;

  typedef struct packed {
    logic [1:0]                   root_count;
    logic signed [COEF_WIDTH-1:0] root_first;
    logic signed [COEF_WIDTH-1:0] root_second;
    logic                         status;
    logic                         saturated;
  } qrs_rsp_t;

endpackage

`default_nettype wire

[design/quadratic_root_solver_unit.sv]
// Quadratic root solver: pipelined discriminant, square root and two dividers.
// Depends on qrs_pkg and quadratic_root_solver_unit_assert.svh.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------
//   request | req_valid/req_ready  | qrs_req_t: coef_a, coef_b, coef_c
//   result  | rsp_valid/rsp_ready  | qrs_rsp_t: count, roots, flags
//
// One request enters per cycle while the pipeline advances. The square root
// resolves one root bit per stage and the two restoring dividers one quotient
// bit per stage.
// Reset clears only the valid bits. The whole pipeline advances together while
// the output register is empty or being taken; a stall freezes every stage.
`default_nettype none

`include "quadratic_root_solver_unit_assert.svh"

module quadratic_root_solver_unit #(
  parameter int FRAC_BITS       = 16,
  parameter int DOUBLE_ROOT_TOL = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire qrs_pkg::qrs_req_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output qrs_pkg::qrs_rsp_t     rsp
);
  import qrs_pkg::*;

  localparam int W   = COEF_WIDTH;
  localparam int H   = (W + 1) / 2;      // low half of a multiplier operand
  localparam int L   = W - H;            // high half
  localparam int DW  = 2 * W + 2;        // discriminant magnitude
  localparam int SW  = W + 1;            // square root, also sqrt stage count
  localparam int RW  = W + 4;            // sqrt partial remainder
  localparam int NW  = W + 3;            // signed numerator -b +/- s
  localparam int QW  = W + 2 + FRAC_BITS; // dividend / quotient, divider stages
  localparam int DVW = W + 1;            // divisor 2|a|

  localparam logic [QW-1:0] LIM_NEG = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - 1'b1;

  typedef struct packed {
    logic                azero;
    logic                an;
    logic [W-1:0]        am;
    logic signed [W:0]   nb;
    logic [1:0]          cnt;
  } meta_t;

  typedef struct packed {
    logic                azero;
    logic [1:0]          cnt;
    logic                neg1;
    logic                neg2;
    logic [DVW-1:0]      dvsr;
  } dside_t;

  logic adv;
  assign adv       = ~rsp_valid | rsp_ready;
  assign req_ready = adv;

  // ---------------- stage 1: magnitudes and partial products ----------------
  logic [W-1:0]    am, bm, cm;
  logic            an, bn, cn;
  logic signed [W:0] nb_in;
  assign an    = req.coef_a[W-1];
  assign bn    = req.coef_b[W-1];
  assign cn    = req.coef_c[W-1];
  assign am    = an ? (~req.coef_a + 1'b1) : req.coef_a;
  assign bm    = bn ? (~req.coef_b + 1'b1) : req.coef_b;
  assign cm    = cn ? (~req.coef_c + 1'b1) : req.coef_c;
  assign nb_in = (W+1)'(0) - {req.coef_b[W-1], req.coef_b};

  logic          s1_v;
  meta_t         s1_meta;
  logic          s1_opp;
  logic [2*H-1:0] s1_bb00, s1_ac00;
  logic [W-1:0]  s1_bbm, s1_ac01, s1_ac10;
  logic [2*L-1:0] s1_bb11, s1_ac11;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= req_valid;
    end
    if (adv) begin
      s1_meta.azero <= (am == '0);
      s1_meta.an    <= an;
      s1_meta.am    <= am;
      s1_meta.nb    <= nb_in;
      s1_meta.cnt   <= ROOTS_NONE;
      s1_opp        <= (an != cn) && (cm != '0);
      s1_bb00       <= bm[H-1:0] * bm[H-1:0];
      s1_bbm        <= bm[H-1:0] * bm[W-1:H];
      s1_bb11       <= bm[W-1:H] * bm[W-1:H];
      s1_ac00       <= am[H-1:0] * cm[H-1:0];
      s1_ac01       <= am[H-1:0] * cm[W-1:H];
      s1_ac10       <= am[W-1:H] * cm[H-1:0];
      s1_ac11       <= am[W-1:H] * cm[W-1:H];
    end
  end

  // ---------------- stage 2: b*b and 4ac ----------------
  logic          s2_v;
  meta_t         s2_meta;
  logic          s2_opp;
  logic [DW-1:0] s2_b2, s2_ac4;
  logic [2*W-1:0] b2_sum, ac_sum;

  assign b2_sum = ((2*W)'(s1_bb11) << (2*H)) + ((2*W)'(s1_bbm) << (H+1))
                + (2*W)'(s1_bb00);
  assign ac_sum = ((2*W)'(s1_ac11) << (2*H)) + ((2*W)'(s1_ac01) << H)
                + ((2*W)'(s1_ac10) << H) + (2*W)'(s1_ac00);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
    if (adv) begin
      s2_meta <= s1_meta;
      s2_opp  <= s1_opp;
      s2_b2   <= {2'b00, b2_sum};
      s2_ac4  <= {ac_sum, 2'b00};
    end
  end

  // ---------------- stage 3: discriminant and root count ----------------
  logic [DW-1:0] dmag;
  logic          dneg;
  logic [1:0]    cnt_next;
  meta_t         s3_meta;

  always_comb begin
    if (s2_opp) begin
      dmag = s2_b2 + s2_ac4;
      dneg = 1'b0;
    end else if (s2_b2 >= s2_ac4) begin
      dmag = s2_b2 - s2_ac4;
      dneg = 1'b0;
    end else begin
      dmag = s2_ac4 - s2_b2;
      dneg = 1'b1;
    end
    if (!dneg && dmag != '0) begin
      cnt_next = ROOTS_TWO;
    end else if (dmag <= DW'(DOUBLE_ROOT_TOL)) begin
      cnt_next = ROOTS_ONE;
    end else begin
      cnt_next = ROOTS_NONE;
    end
  end

  always_comb begin
    s3_meta     = s2_meta;
    s3_meta.cnt = cnt_next;
  end

  // square root pipeline: index k feeds bit step k
  logic          sq_v    [0:SW];
  meta_t         sq_meta [0:SW];
  logic [DW-1:0] sq_rad  [0:SW];
  logic [RW-1:0] sq_rem  [0:SW];
  logic [SW-1:0] sq_root [0:SW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= s2_v;
    end
    if (adv) begin
      sq_meta[0]     <= s3_meta;
      sq_rad[0]      <= (cnt_next == ROOTS_TWO) ? dmag : '0;
      sq_rem[0]      <= '0;
      sq_root[0]     <= '0;
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [RW-1:0] t_rem, trial;
    logic          fits;
    assign t_rem = {sq_rem[k][RW-3:0], sq_rad[k][DW-1:DW-2]};
    assign trial = RW'({sq_root[k], 2'b01});
    assign fits  = (t_rem >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (adv) begin
        sq_meta[k+1] <= sq_meta[k];
        sq_rad[k+1]  <= {sq_rad[k][DW-3:0], 2'b00};
        sq_rem[k+1]  <= fits ? (t_rem - trial) : t_rem;
        sq_root[k+1] <= {sq_root[k][SW-2:0], fits};
      end
    end
  end

  // ---------------- numerators -b +/- s ----------------
  logic signed [NW-1:0] num1, num2;
  logic [NW-2:0]        mag1, mag2;
  meta_t                fm;
  assign fm   = sq_meta[SW];
  assign num1 = NW'(fm.nb) + NW'({1'b0, sq_root[SW]});
  assign num2 = NW'(fm.nb) - NW'({1'b0, sq_root[SW]});
  assign mag1 = num1[NW-1] ? (NW-1)'(-num1) : (NW-1)'(num1);
  assign mag2 = num2[NW-1] ? (NW-1)'(-num2) : (NW-1)'(num2);

  logic          dv_v    [0:QW];
  dside_t        dv_side [0:QW];
  logic [W-1:0]  dv_rem1 [0:QW];
  logic [W-1:0]  dv_rem2 [0:QW];
  logic [QW-1:0] dv_q1   [0:QW];
  logic [QW-1:0] dv_q2   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SW];
    end
    if (adv) begin
      dv_side[0].azero <= fm.azero;
      dv_side[0].cnt   <= fm.cnt;
      dv_side[0].neg1  <= num1[NW-1] ^ fm.an;
      dv_side[0].neg2  <= num2[NW-1] ^ fm.an;
      dv_side[0].dvsr  <= {fm.am, 1'b0};
      dv_rem1[0]       <= '0;
      dv_rem2[0]       <= '0;
      dv_q1[0]         <= {mag1, {FRAC_BITS{1'b0}}};
      dv_q2[0]         <= {mag2, {FRAC_BITS{1'b0}}};
    end
  end

  // two restoring dividers, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [W:0] t1, t2;
    logic       f1, f2;
    logic [W:0] d1, d2;
    assign t1 = {dv_rem1[k], dv_q1[k][QW-1]};
    assign t2 = {dv_rem2[k], dv_q2[k][QW-1]};
    assign f1 = (t1 >= dv_side[k].dvsr);
    assign f2 = (t2 >= dv_side[k].dvsr);
    assign d1 = t1 - dv_side[k].dvsr;
    assign d2 = t2 - dv_side[k].dvsr;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
      if (adv) begin
        dv_side[k+1] <= dv_side[k];
        dv_rem1[k+1] <= f1 ? d1[W-1:0] : t1[W-1:0];
        dv_rem2[k+1] <= f2 ? d2[W-1:0] : t2[W-1:0];
        dv_q1[k+1]   <= {dv_q1[k][QW-2:0], f1};
        dv_q2[k+1]   <= {dv_q2[k][QW-2:0], f2};
      end
    end
  end

  // ---------------- saturation and result register ----------------
  dside_t        fs;
  logic [QW-1:0] lim1, lim2, m1, m2;
  logic          sat1, sat2;
  logic [W-1:0]  r1, r2;
  qrs_rsp_t      rsp_next;

  assign fs   = dv_side[QW];
  assign lim1 = fs.neg1 ? LIM_NEG : LIM_POS;
  assign lim2 = fs.neg2 ? LIM_NEG : LIM_POS;
  assign sat1 = dv_q1[QW] > lim1;
  assign sat2 = dv_q2[QW] > lim2;
  assign m1   = sat1 ? lim1 : dv_q1[QW];
  assign m2   = sat2 ? lim2 : dv_q2[QW];
  assign r1   = fs.neg1 ? (~m1[W-1:0] + 1'b1) : m1[W-1:0];
  assign r2   = fs.neg2 ? (~m2[W-1:0] + 1'b1) : m2[W-1:0];

  always_comb begin
    rsp_next = '0;
    if (fs.azero) begin
      rsp_next.status = STATUS_A_ZERO;
    end else begin
      rsp_next.status = STATUS_OK;
      case (fs.cnt)
        ROOTS_TWO: begin
          rsp_next.root_count  = ROOTS_TWO;
          rsp_next.root_first  = r1;
          rsp_next.root_second = r2;
          rsp_next.saturated   = sat1 | sat2;
        end
        ROOTS_ONE: begin
          rsp_next.root_count = ROOTS_ONE;
          rsp_next.root_first = r1;
          rsp_next.saturated  = sat1;
        end
        default: begin
          rsp_next.root_count = ROOTS_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= dv_v[QW];
    end
    if (adv) begin
      rsp <= rsp_next;
    end
  end

  // ---------------- checks ----------------
  `QRS_ASSERT_IMPL(a_zero_no_roots, rsp_valid && rsp.status == STATUS_A_ZERO,
    rsp.root_count == ROOTS_NONE && rsp.root_first == '0 && !rsp.saturated)
  `QRS_ASSERT_IMPL(a_count_range, rsp_valid, rsp.root_count <= ROOTS_TWO)
  `QRS_ASSERT_IMPL(a_second_unused, rsp_valid && rsp.root_count != ROOTS_TWO,
    rsp.root_second == '0)
  `QRS_ASSERT_IMPL(a_stall_freeze, rsp_valid && !rsp_ready, !req_ready)

endmodule

`default_nettype wire

[tb/testbench.sv]
// Testbench for quadratic_root_solver_unit: random and corner coefficient sets,
// results checked against an in-bench fixed-point root predictor.
// Depends on qrs_pkg and the solver RTL.
`default_nettype none

module testbench;
  import qrs_pkg::*;

  localparam int FRAC = 16;
  localparam int TOL  = 4;
  localparam int W    = COEF_WIDTH;
  localparam int LATENCY = 3 + (W + 1) + 1 + (W + 2 + FRAC) + 1;

  // Predicts and checks solver results; pending queue holds roots still owed.
  class root_scoreboard;
    qrs_rsp_t pending_roots[$];
    int       mismatches;

    // Scale num by 2^FRAC, divide by 2a (truncating), clip to W bits.
    function automatic logic [W-1:0] scaled_root(logic signed [W+2:0] num,
                                                 logic a_neg, logic [W:0] a2,
                                                 ref logic sat);
      logic [W+2:0]   mag;
      logic [127:0]   quo;
      logic           neg;
      logic [W-1:0]   lim;
      mag = num[W+2] ? -num : num;
      neg = num[W+2] != a_neg;
      quo = ({{(128-W-3){1'b0}}, mag} << FRAC) / a2;
      lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      if (quo > {{(128-W){1'b0}}, lim}) begin
        sat = 1'b1;
        quo = 128'(lim);
      end
      return neg ? -quo[W-1:0] : quo[W-1:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if ({64'd0, t} * {64'd0, t} <= v) r = t;
      end
      return r;
    endfunction

    function void note_request(qrs_req_t q);
      qrs_rsp_t          e;
      logic signed [127:0] disc;
      logic [127:0]      dmag;
      logic signed [W+2:0] nb;
      logic [63:0]       s;
      logic              sat;
      logic [W:0]        a2;
      e = '0;
      sat = 1'b0;
      if (q.coef_a == 0) begin
        e.status = STATUS_A_ZERO;
        e.root_count = ROOTS_NONE;
      end else begin
        disc = 128'(signed'(q.coef_b)) * 128'(signed'(q.coef_b))
             - 128'sd4 * 128'(signed'(q.coef_a)) * 128'(signed'(q.coef_c));
        dmag = disc < 0 ? -disc : disc;
        nb = -(W+3)'(signed'(q.coef_b));
        a2 = {(q.coef_a[W-1] ? -q.coef_a : q.coef_a), 1'b0};
        if (disc > 0) begin
          s = floor_sqrt(dmag);
          e.root_count  = ROOTS_TWO;
          e.root_first  = scaled_root(nb + signed'({2'b0, s[W:0]}), q.coef_a[W-1], a2, sat);
          e.root_second = scaled_root(nb - signed'({2'b0, s[W:0]}), q.coef_a[W-1], a2, sat);
        end else if (dmag <= TOL) begin
          e.root_count = ROOTS_ONE;
          e.root_first = scaled_root(nb, q.coef_a[W-1], a2, sat);
        end
        e.saturated = sat;
      end
      pending_roots.push_back(e);
    endfunction

    function void check_result(qrs_rsp_t got);
      qrs_rsp_t e;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending_roots.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp cnt=%0d r1=%h r2=%h st=%b sat=%b  got cnt=%0d r1=%h r2=%h st=%b sat=%b",
                   e.root_count, e.root_first, e.root_second, e.status, e.saturated,
                   got.root_count, got.root_first, got.root_second, got.status, got.saturated);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  qrs_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  qrs_rsp_t rsp;

  root_scoreboard sb;

  quadratic_root_solver_unit u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
    end
  end

  // Drive one request; wait a random gap first, hold until accepted.
  // Valid stays high into the next request when there is no gap.
  task automatic send_request(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
    int gap;
    gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{coef_a: a, coef_b: b, coef_c: c};
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      2: return W'(signed'($urandom_range(0, 8) - 4)) << FRAC;
      3: return W'(signed'($urandom_range(0, 64) - 32));
      4: return W'(signed'(int'($urandom_range(0, 2000)) - 1000)) << ($urandom_range(8, 14));
      default: return W'($urandom_range(0, 20) << $urandom_range(0, 24));
    endcase
  endfunction

  // Receiver side: random stall per result, with runs of no stalling.
  initial begin
    int wait_cycles;
    rsp_ready = 1'b0;
    @(negedge clk);
    forever begin
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      if (wait_cycles != 0) begin
        rsp_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [W-1:0] one;
    logic [W-1:0] a_r;
    logic [W-1:0] r1;
    logic [W-1:0] r2;
    sb = new();
    one = W'(1) << FRAC;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero a, double root, tiny discriminant, saturation, extremes.
    send_request('0, one, one);
    send_request('0, '1, {1'b1, {(W-1){1'b0}}});
    send_request(one, W'(-2) << FRAC, one);              // (x-1)^2
    send_request(one, '0, W'(-4) << FRAC);               // +-2
    send_request(one, '0, one);                          // no roots
    send_request(W'(1), W'(2), W'(1));                   // b^2 - 4ac == 0
    send_request(W'(1), W'(3), W'(2));                   // d = 1
    send_request(W'(1), W'(2), W'(0));
    send_request(W'(1), {1'b0, {(W-1){1'b1}}}, '0);      // saturates
    send_request({1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}});
    send_request({1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}});
    send_request({1'b1, {(W-1){1'b0}}}, '0, {1'b0, {(W-1){1'b1}}});
    send_request('1, '1, '1);
    send_request(W'(-1) << FRAC, W'(3) << FRAC, '0);
    send_request(one, W'(2) << FRAC, one + W'(1));

    for (int i = 0; i < 1300; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        // Build from chosen roots so double and two-root cases stay common.
        a_r = W'(signed'($urandom_range(1, 8))) << FRAC;
        if ($urandom & 1) a_r = -a_r;
        r1 = W'(signed'($urandom_range(0, 40) - 20));
        r2 = ($urandom_range(0, 1)) ? r1 : W'(signed'($urandom_range(0, 40) - 20));
        send_request(a_r, W'(-(signed'(a_r) >>> FRAC) * (signed'(r1) + signed'(r2))) << FRAC,
                     W'((signed'(a_r) >>> FRAC) * signed'(r1) * signed'(r2)) << FRAC);
      end else begin
        send_request(rand_coef(), rand_coef(), rand_coef());
      end
    end
    req_valid <= 1'b0;

    while (sb.pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: generous bound over slowest legal run.
  initial begin
    #(12 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
